### src/rlb_pkg.sv
// ----------------------------------------------------------------------------
// rlb_pkg
// Shared constants and register indexes for the resonant lowpass biquad.
// ----------------------------------------------------------------------------
package rlb_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 24;

    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_COEF_C1 = 2'd0,
        REG_COEF_C2 = 2'd1,
        REG_COEF_C3 = 2'd2
    } cfg_index_t;

endpackage

### src/rlb_coef_regs.sv
// ----------------------------------------------------------------------------
// rlb_coef_regs
// Coefficient register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module rlb_coef_regs #(
    parameter int COEF_BITS = rlb_pkg::COEF_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic [rlb_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [COEF_BITS-1:0]                  cfg_data,
    output logic signed [COEF_BITS-1:0]           coef_c1,
    output logic signed [COEF_BITS-1:0]           coef_c2,
    output logic signed [COEF_BITS-1:0]           coef_c3
);

    logic signed [COEF_BITS-1:0] c1_reg, c2_reg, c3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end else if (cfg_valid) begin
            case (rlb_pkg::cfg_index_t'(cfg_index))
                rlb_pkg::REG_COEF_C1: c1_reg <= $signed(cfg_data);
                rlb_pkg::REG_COEF_C2: c2_reg <= $signed(cfg_data);
                rlb_pkg::REG_COEF_C3: c3_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    assign coef_c1 = c1_reg;
    assign coef_c2 = c2_reg;
    assign coef_c3 = c3_reg;

endmodule

### src/rlb_datapath.sv
// ----------------------------------------------------------------------------
// rlb_datapath
// Biquad sum: three parallel multiplies, exact sum, round half up, saturate.
// ----------------------------------------------------------------------------
module rlb_datapath #(
    parameter int SAMPLE_BITS = rlb_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = rlb_pkg::COEF_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic signed [SAMPLE_BITS-1:0] x1,
    input  logic signed [SAMPLE_BITS-1:0] x2,
    input  logic signed [SAMPLE_BITS-1:0] y1,
    input  logic signed [SAMPLE_BITS-1:0] y2,
    input  logic signed [COEF_BITS-1:0]   c1,
    input  logic signed [COEF_BITS-1:0]   c2,
    input  logic signed [COEF_BITS-1:0]   c3,
    output logic signed [SAMPLE_BITS-1:0] y,
    output logic                          clip
);

    localparam int XS_W  = SAMPLE_BITS + 2;
    localparam int P3_W  = XS_W + COEF_BITS;
    localparam int P_W   = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W = SAMPLE_BITS + COEF_BITS + 5;
    localparam int SH    = COEF_BITS - 2;
    localparam int Q_W   = ACC_W - SH;

    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (SH - 1);
    localparam logic [Q_W-1:0]   SMAX = {{(Q_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [Q_W-1:0]   SMIN = {{(Q_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [XS_W-1:0]  xs;
    logic signed [P3_W-1:0]  p3;
    logic signed [P_W-1:0]   p2, p1;
    logic signed [ACC_W-1:0] sum, rnd;
    logic signed [Q_W-1:0]   q;

    always_comb begin
        xs  = XS_W'(x) + (XS_W'(x1) <<< 1) + XS_W'(x2);
        p3  = P3_W'(xs) * P3_W'(c3);
        p2  = P_W'(y1) * P_W'(c2);
        p1  = P_W'(y2) * P_W'(c1);
        sum = (ACC_W'(p3) + ACC_W'(p2) - ACC_W'(p1)) <<< 1;
        rnd = sum + $signed(HALF);
        q   = Q_W'(rnd >>> SH);
        if (q > $signed(SMAX)) begin
            y    = SMAX[SAMPLE_BITS-1:0];
            clip = 1'b1;
        end else if (q < $signed(SMIN)) begin
            y    = SMIN[SAMPLE_BITS-1:0];
            clip = 1'b1;
        end else begin
            y    = q[SAMPLE_BITS-1:0];
            clip = 1'b0;
        end
    end

endmodule

### src/resonant_lowpass_biquad.sv
// ----------------------------------------------------------------------------
// resonant_lowpass_biquad
// Direct-form-I resonant lowpass biquad, one sample in, one sample out.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; the result register
//   loads when the result stage is empty or the receiver accepts.
// Throughput: one sample per cycle while results are accepted; the sum and
//   the y1 feedback close in the single stage between the two registers.
// Reset: coefficients and the x/y history clear to zero, both stages empty.
module resonant_lowpass_biquad #(
    parameter int SAMPLE_BITS = rlb_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = rlb_pkg::COEF_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rlb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]               cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_sample_out,
    output logic                               m_clipped
);

    logic signed [COEF_BITS-1:0]   c1, c2, c3;
    logic signed [SAMPLE_BITS-1:0] y_calc;
    logic                          clip_calc;
    logic                          advance;

    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_clip_reg;
    logic signed [SAMPLE_BITS-1:0] prev_in_1_reg, prev_in_2_reg;
    logic signed [SAMPLE_BITS-1:0] prev_out_1_reg, prev_out_2_reg;

    rlb_coef_regs #(
        .COEF_BITS (COEF_BITS)
    ) u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef_c1   (c1),
        .coef_c2   (c2),
        .coef_c3   (c3)
    );

    rlb_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dp (
        .x    (in_sample_reg),
        .x1   (prev_in_1_reg),
        .x2   (prev_in_2_reg),
        .y1   (prev_out_1_reg),
        .y2   (prev_out_2_reg),
        .c1   (c1),
        .c2   (c2),
        .c3   (c3),
        .y    (y_calc),
        .clip (clip_calc)
    );

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample_in;
        end
    end

    // result stage and filter history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            prev_in_1_reg  <= '0;
            prev_in_2_reg  <= '0;
            prev_out_1_reg <= '0;
            prev_out_2_reg <= '0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                prev_in_1_reg  <= in_sample_reg;
                prev_in_2_reg  <= prev_in_1_reg;
                prev_out_1_reg <= y_calc;
                prev_out_2_reg <= prev_out_1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_sample_reg <= y_calc;
            out_clip_reg   <= clip_calc;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_sample_reg;
    assign m_clipped    = out_clip_reg;

    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg && !in_valid_reg)
        else $error("pipeline not empty after reset");

    a_clip_at_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_clip_reg |->
            out_sample_reg == S_MAX || out_sample_reg == S_MIN)
        else $error("clipped result not at a rail");

    a_feedback_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_valid_reg |=> prev_out_1_reg == out_sample_reg)
        else $error("feedback history differs from emitted result");

    a_input_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_valid_reg |=> prev_in_2_reg == $past(prev_in_1_reg))
        else $error("input history did not shift");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty result stage");

endmodule

### tb/sv/biquad_checker.sv
// ----------------------------------------------------------------------------
// biquad_checker
// Watches the coefficient, sample and result channels of the biquad. It
// keeps its own copy of the coefficients and the x/y history, predicts each
// filtered sample at its input transfer, and compares every result transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module biquad_checker #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [rlb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [COEF_BITS-1:0]                cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample_in,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [SAMPLE_BITS-1:0]       m_sample_out,
    input  logic                                m_clipped,
    output int                                  mismatches,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rlb_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          clipped;
    } biquad_out_t;

    logic signed [COEF_BITS-1:0]   k1, k2, k3;
    logic signed [SAMPLE_BITS-1:0] x_d1, x_d2, y_d1, y_d2;
    biquad_out_t                   expected_samples[$];
    int                            fail_cnt = 0;

    assign mismatches = fail_cnt;

    // Exact sum at 2^-(SAMPLE_BITS-1+COEF_BITS-2), round half up, saturate.
    function automatic biquad_out_t biquad_next(input logic signed [SAMPLE_BITS-1:0] x);
        longint      tap_sum, acc, q, smax, smin;
        biquad_out_t r;
        smax    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        smin    = -smax - 1;
        tap_sum = longint'(x) + 2 * longint'(x_d1) + longint'(x_d2);
        acc     = 2 * longint'(k3) * tap_sum + 2 * longint'(k2) * longint'(y_d1)
                - 2 * longint'(k1) * longint'(y_d2);
        q       = (acc + (longint'(1) <<< (COEF_BITS - 3))) >>> (COEF_BITS - 2);
        r.clipped = (q > smax) || (q < smin);
        if (q > smax) begin
            q = smax;
        end else if (q < smin) begin
            q = smin;
        end
        r.sample = q[SAMPLE_BITS-1:0];
        x_d2 = x_d1;
        x_d1 = x;
        y_d2 = y_d1;
        y_d1 = r.sample;
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        biquad_out_t want;
        if (!aresetn) begin
            k1 = '0;
            k2 = '0;
            k3 = '0;
            x_d1 = '0;
            x_d2 = '0;
            y_d1 = '0;
            y_d2 = '0;
            expected_samples.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_COEF_C1: k1 = cfg_data;
                    REG_COEF_C2: k2 = cfg_data;
                    REG_COEF_C3: k3 = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    if (fail_cnt < 10) begin
                        $display("unexpected result transfer: sample %0d clipped %0b",
                                 m_sample_out, m_clipped);
                    end
                    fail_cnt++;
                end else begin
                    want = expected_samples.pop_front();
                    if (want.sample !== m_sample_out || want.clipped !== m_clipped) begin
                        if (fail_cnt < 10) begin
                            $display({"result mismatch: expected sample %0d clipped %0b,",
                                      " got sample %0d clipped %0b"},
                                     $signed(want.sample), want.clipped,
                                     m_sample_out, m_clipped);
                        end
                        fail_cnt++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_samples.push_back(biquad_next(s_sample_in));
            end
        end
        pending <= expected_samples.size();
    end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the resonant lowpass biquad. Runs a directed
// set (reset state, clipping both ways, rounding ties, extreme feedback,
// writes to the unused index), then random samples under a series of
// coefficient settings, with sender and receiver back-pressure phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rlb_pkg::*;

    localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
    localparam int COEF_BITS    = COEF_BITS_DEF;
    localparam int SMAX         = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SMIN         = -SMAX - 1;
    localparam int CMAX         = (1 << (COEF_BITS - 1)) - 1;
    localparam int CMIN         = -CMAX - 1;
    localparam int SEGMENTS     = 12;
    localparam int SEG_ITEMS    = 150;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
    logic [COEF_BITS-1:0]          cfg_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample_in = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_sample_out;
    logic                          m_clipped;

    int mismatches;
    int pending;
    int cycle_cnt = 0;
    int send_idle_pct = 38;
    int recv_idle_pct = 61;

    resonant_lowpass_biquad #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_clipped    (m_clipped)
    );

    biquad_checker #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_clipped    (m_clipped),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= COEF_BITS'(val);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic write_coefs(input int c1, input int c2, input int c3,
                               input bit poke_unused);
        write_reg(REG_COEF_C1, c1);
        write_reg(REG_COEF_C2, c2);
        write_reg(REG_COEF_C3, c3);
        if (poke_unused) begin
            write_reg(REG_UNUSED, int'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // valid stays up between back-to-back transfers; it only drops for a gap
    task automatic send_sample(input int v);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_sample_in <= SAMPLE_BITS'(v);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic int corner_coef();
        case ($urandom_range(0, 4))
            0:       return CMAX;
            1:       return CMIN;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    initial begin
        int c1, c2, c3, lim, r;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // coefficients at reset value: output stays zero
        send_sample(0);
        send_sample(SMAX);
        send_sample(SMIN);
        drain();

        // large gain: clip high then low
        write_coefs(0, 0, CMAX, 1'b1);
        send_sample(SMAX);
        send_sample(SMAX);
        send_sample(SMIN);
        send_sample(SMIN);
        send_sample(0);
        send_sample(0);
        drain();

        // unit c3: half-LSB ties of both signs
        write_coefs(0, 0, 1, 1'b0);
        send_sample(1 << 20);
        send_sample(0);
        send_sample(0);
        send_sample(-(1 << 20));
        send_sample(0);
        send_sample(0);
        send_sample(1);
        send_sample(-1);
        drain();

        // extreme feedback taps, clamped output feeds back
        write_coefs(CMIN, CMAX, CMIN, 1'b0);
        send_sample(SMAX);
        send_sample(SMIN);
        send_sample(0);
        send_sample(0);
        send_sample(SMAX);
        drain();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 4)
                0: begin
                    send_idle_pct = 38;
                    recv_idle_pct = 61;
                end
                1: begin
                    send_idle_pct = 61;
                    recv_idle_pct = 38;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (seg % 4)
                0, 3: begin
                    // stable resonant setting
                    c1  = int'($urandom_range(0, (1 << 21) - (1 << 17)));
                    lim = (1 << 21) + c1 - (1 << 17);
                    c2  = int'($urandom_range(0, 2 * lim)) - lim;
                    c3  = int'($urandom_range(0, 1 << 17)) - (1 << 16);
                    write_coefs(c1, c2, c3, seg == 3);
                end
                1: write_coefs(int'($urandom), int'($urandom), int'($urandom), 1'b1);
                default: write_coefs(corner_coef(), corner_coef(), corner_coef(), 1'b0);
            endcase
            for (int i = 0; i < SEG_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    send_sample(int'($urandom));
                end else if (r < 85) begin
                    send_sample(int'($urandom_range(0, 512)) - 256);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       send_sample(SMAX);
                        1:       send_sample(SMIN);
                        2:       send_sample(0);
                        default: send_sample(-1);
                    endcase
                end
            end
            drain();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
